// ===== rtl/lev_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lev_pkg
// Shared constants for the Lorenz Euler stepper with normalized output.
// ----------------------------------------------------------------------------
package lev_pkg;

  // default number formats
  localparam int LEV_FRAC_BITS = 24;
  localparam int LEV_WORD_BITS = 48;
  localparam int LEV_MAX_BURST = 64;

  // normalized output: signed Q2.30 in 32 bits
  localparam int NORM_FRAC = 30;
  localparam int NORM_W    = 32;

  // field widths
  localparam int CNT_W  = 32;
  localparam int WARM_W = 16;
  localparam int BLEN_W = 7;
  localparam int BIDX_W = 6;
  localparam int OP_W   = 2;

  // configuration port
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 6;
  localparam int REG_W  = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_STEP    = 2'd0;
  localparam logic [OP_W-1:0] OP_BURST   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  // register indexes
  localparam logic [REG_W-1:0] REG_SIGMA  = 3'd0;
  localparam logic [REG_W-1:0] REG_RHO    = 3'd1;
  localparam logic [REG_W-1:0] REG_BETA   = 3'd2;
  localparam logic [REG_W-1:0] REG_STEP   = 3'd3;
  localparam logic [REG_W-1:0] REG_STARTX = 3'd4;
  localparam logic [REG_W-1:0] REG_STARTY = 3'd5;
  localparam logic [REG_W-1:0] REG_STARTZ = 3'd6;
  localparam logic [REG_W-1:0] REG_WARMUP = 3'd7;

endpackage

// ===== rtl/lev_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lev_mul
// Shift-add fixed point multiplier, one multiplier bit per cycle. The product
// is shifted right by FRAC_BITS toward minus infinity and saturated.
// ----------------------------------------------------------------------------
module lev_mul import lev_pkg::*; #(
  parameter int WORD_BITS = LEV_WORD_BITS,
  parameter int FRAC_BITS = LEV_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [WORD_BITS-1:0] op_a,
  input  logic signed [WORD_BITS-1:0] op_b,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] result
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(W);
  localparam int QW = 2*W - FRAC_BITS + 1;
  localparam logic [W-1:0] WMAX_U = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN_U = {1'b1, {(W-1){1'b0}}};

  logic          busy_r, fin_r, done_r, neg_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  mcand_r;
  logic [2*W-1:0] prod_r;
  logic signed [W-1:0] res_r;

  logic [W-1:0]  mag_a, mag_b;
  logic [W:0]    upper;
  logic [QW-1:0] q_raw, q_rnd;
  logic          rnd;
  logic signed [W-1:0] res_nxt;

  // operand magnitudes
  assign mag_a = op_a[W-1] ? (~op_a + 1'b1) : op_a;
  assign mag_b = op_b[W-1] ? (~op_b + 1'b1) : op_b;

  // one add per multiplier bit
  assign upper = {1'b0, prod_r[2*W-1:W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);

  // scale back, round toward minus infinity, saturate
  always_comb begin
    q_raw = QW'(prod_r[2*W-1:FRAC_BITS]);
    rnd   = neg_r && (|prod_r[FRAC_BITS-1:0]);
    q_rnd = q_raw + QW'(rnd);
    if (!neg_r) begin
      res_nxt = (q_rnd > QW'(WMAX_U)) ? signed'(WMAX_U) : signed'(q_rnd[W-1:0]);
    end else begin
      res_nxt = (q_rnd > QW'(WMIN_U)) ? signed'(WMIN_U) : signed'(~q_rnd[W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        neg_r   <= op_a[W-1] ^ op_b[W-1];
        mcand_r <= mag_a;
        prod_r  <= {{W{1'b0}}, mag_b};
      end else if (busy_r) begin
        prod_r <= {upper, prod_r[W-1:1]};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CW'(W-1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        res_r  <= res_nxt;
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== rtl/lev_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lev_div
// Restoring divider, one quotient bit per cycle: num * 2^30 / den, truncated
// toward zero and saturated to signed Q2.30.
// ----------------------------------------------------------------------------
module lev_div import lev_pkg::*; #(
  parameter int WORD_BITS = LEV_WORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [WORD_BITS-1:0] num,
  input  logic        [WORD_BITS-1:0] den,
  output logic                        done,
  output logic signed [NORM_W-1:0]    quot
);

  localparam int W  = WORD_BITS;
  localparam int NW = W + NORM_FRAC;
  localparam int CW = $clog2(NW);
  localparam logic [NW-1:0] QPOS_MAX = NW'({1'b0, {(NORM_W-1){1'b1}}});
  localparam logic [NW-1:0] QNEG_MAX = NW'({1'b1, {(NORM_W-1){1'b0}}});

  logic          busy_r, fin_r, done_r, neg_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  den_r, rem_r;
  logic [NW-1:0] n_r;
  logic signed [NORM_W-1:0] quot_r;

  logic [W-1:0] mag_n;
  logic [W:0]   rsh, rdif;
  logic         ge;
  logic signed [NORM_W-1:0] quot_nxt;

  assign mag_n = num[W-1] ? (~num + 1'b1) : num;

  // trial subtract
  assign rsh  = {rem_r, n_r[NW-1]};
  assign ge   = rsh >= {1'b0, den_r};
  assign rdif = rsh - {1'b0, den_r};

  // saturate the quotient and apply the sign
  always_comb begin
    if (!neg_r) begin
      quot_nxt = (n_r > QPOS_MAX) ? signed'(QPOS_MAX[NORM_W-1:0])
                                  : signed'(n_r[NORM_W-1:0]);
    end else begin
      quot_nxt = (n_r > QNEG_MAX) ? signed'(QNEG_MAX[NORM_W-1:0])
                                  : signed'(~n_r[NORM_W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= num[W-1];
        den_r  <= den;
        rem_r  <= '0;
        n_r    <= {mag_n, {NORM_FRAC{1'b0}}};
      end else if (busy_r) begin
        rem_r <= ge ? rdif[W-1:0] : rsh[W-1:0];
        n_r   <= {n_r[NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW-1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        quot_r <= quot_nxt;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== rtl/lorenz_euler_normalized.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorenz_euler_normalized
// Lorenz attractor, forward Euler steps in signed fixed point, each position
// reported divided by the running per-axis span as signed Q2.30.
// ----------------------------------------------------------------------------
// Each step runs 7 multiplies on the shared multiplier, one update state
// and 3 divisions. One input beat is taken at a time, and only while idle;
// the steps of a burst run one after another, each held until its result
// beat is taken. The serial multiplier and divider set the pace.
// Synchronous active-low reset loads the register defaults and the start
// point, clears the minima and the count and sets the maxima to one million.
// ----------------------------------------------------------------------------
module lorenz_euler_normalized import lev_pkg::*; #(
  parameter int FRAC_BITS = LEV_FRAC_BITS,
  parameter int WORD_BITS = LEV_WORD_BITS,
  parameter int MAX_BURST = LEV_MAX_BURST
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,     // [1:0] operation, [8:2] burst_len
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [135:0]      out_tdata,    // norm_x, norm_y, norm_z,
                                          // step_number, burst_index
  output logic [1:0]        out_tuser,    // [0] past_warmup, [1] from_burst
  output logic              out_tlast,
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int W  = WORD_BITS;
  localparam int LW = $clog2(MAX_BURST + 1);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [63:0] WMAX_64  = (64'd1 << (W-1)) - 64'd1;
  localparam logic [63:0] ONE_Q    = 64'd1 << FRAC_BITS;
  localparam logic [63:0] MILL_64  = 64'd1000000 << FRAC_BITS;
  localparam logic [W-1:0] MILLION = (MILL_64 > WMAX_64) ? WMAX : MILL_64[W-1:0];
  localparam logic [63:0] SIGMA_64 = 64'd10 << FRAC_BITS;
  localparam logic [63:0] RHO_64   = 64'd28 << FRAC_BITS;
  localparam logic [63:0] BETA_64  = ((64'd16 << FRAC_BITS) + 64'd3) / 64'd6;
  localparam logic [63:0] STEP_64  = (ONE_Q + 64'd50) / 64'd100;
  localparam logic [63:0] STARTX_64 = (ONE_Q + 64'd5) / 64'd10;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // multiply micro-ops of one Euler step
  localparam logic [2:0] U_HSIG  = 3'd0;  // h*sigma
  localparam logic [2:0] U_XN    = 3'd1;  // (h*sigma)*(y-x)
  localparam logic [2:0] U_XRZ   = 3'd2;  // x*(rho-z)
  localparam logic [2:0] U_YN    = 3'd3;  // h*(x*(rho-z)-y)
  localparam logic [2:0] U_XY    = 3'd4;  // x*y
  localparam logic [2:0] U_BZ    = 3'd5;  // beta*z
  localparam logic [2:0] U_ZN    = 3'd6;  // h*(x*y-beta*z)

  // saturating arithmetic on the word
  function automatic logic signed [W-1:0] qsat(input logic signed [W:0] v);
    logic signed [W-1:0] r;
    if (v[W] != v[W-1]) r = v[W] ? WMIN : WMAX;
    else                r = v[W-1:0];
    return r;
  endfunction

  function automatic logic signed [W-1:0] qadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    return qsat({a[W-1], a} + {b[W-1], b});
  endfunction

  function automatic logic signed [W-1:0] qsub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    return qsat({a[W-1], a} - {b[W-1], b});
  endfunction

  // configuration registers
  logic signed [W-1:0] sigma_r, rho_r, beta_r, h_r, sx_r, sy_r, sz_r;
  logic [WARM_W-1:0]   warm_r;

  // state
  logic [2:0]          state_r, uop_r;
  logic signed [W-1:0] pos_r [3];
  logic signed [W-1:0] np_r  [3];
  logic signed [W-1:0] min_r [3];
  logic signed [W-1:0] max_r [3];
  logic signed [W-1:0] ta_r, tb_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [LW-1:0]       len_r, idx_r;
  logic                burst_r;
  logic [1:0]          axis_r;
  logic                mul_go_r, div_go_r;

  // result registers
  logic                     out_valid_r;
  logic signed [NORM_W-1:0] norm_r [3];
  logic [CNT_W-1:0]         snum_r;
  logic                     warm_ok_r, last_r;
  logic [BIDX_W-1:0]        bidx_r;

  logic                cfg_wr;
  logic [REG_W-1:0]    cfg_idx;
  logic [OP_W-1:0]     in_op;
  logic [BLEN_W-1:0]   in_len;
  logic [LW-1:0]       len_clamp;
  logic                in_acc;
  logic signed [W-1:0] mul_a, mul_b, mul_res;
  logic                mul_done, div_done;
  logic signed [NORM_W-1:0] div_q;
  logic signed [W-1:0] span_abs, span, div_num;
  logic signed [W-1:0] mn_sel, mx_sel;

  // APB register file
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_idx)
      REG_SIGMA:  cfg_prdata = CFG_DW'(sigma_r);
      REG_RHO:    cfg_prdata = CFG_DW'(rho_r);
      REG_BETA:   cfg_prdata = CFG_DW'(beta_r);
      REG_STEP:   cfg_prdata = CFG_DW'(h_r);
      REG_STARTX: cfg_prdata = CFG_DW'(sx_r);
      REG_STARTY: cfg_prdata = CFG_DW'(sy_r);
      REG_STARTZ: cfg_prdata = CFG_DW'(sz_r);
      REG_WARMUP: cfg_prdata = CFG_DW'(warm_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= SIGMA_64[W-1:0];
      rho_r   <= RHO_64[W-1:0];
      beta_r  <= BETA_64[W-1:0];
      h_r     <= STEP_64[W-1:0];
      sx_r    <= STARTX_64[W-1:0];
      sy_r    <= '0;
      sz_r    <= '0;
      warm_r  <= WARM_W'(1000);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SIGMA:  sigma_r <= cfg_pwdata[W-1:0];
        REG_RHO:    rho_r   <= cfg_pwdata[W-1:0];
        REG_BETA:   beta_r  <= cfg_pwdata[W-1:0];
        REG_STEP:   h_r     <= cfg_pwdata[W-1:0];
        REG_STARTX: sx_r    <= cfg_pwdata[W-1:0];
        REG_STARTY: sy_r    <= cfg_pwdata[W-1:0];
        REG_STARTZ: sz_r    <= cfg_pwdata[W-1:0];
        REG_WARMUP: warm_r  <= cfg_pwdata[WARM_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_op     = in_tdata[OP_W-1:0];
  assign in_len    = in_tdata[OP_W+BLEN_W-1:OP_W];
  assign len_clamp = (32'(in_len) > MAX_BURST) ? LW'(MAX_BURST) : LW'(in_len);

  // operand select for the shared multiplier
  always_comb begin
    case (uop_r)
      U_HSIG:  begin mul_a = h_r;      mul_b = sigma_r; end
      U_XN:    begin mul_a = ta_r;     mul_b = qsub(pos_r[1], pos_r[0]); end
      U_XRZ:   begin mul_a = pos_r[0]; mul_b = qsub(rho_r, pos_r[2]); end
      U_YN:    begin mul_a = h_r;      mul_b = qsub(ta_r, pos_r[1]); end
      U_XY:    begin mul_a = pos_r[0]; mul_b = pos_r[1]; end
      U_BZ:    begin mul_a = beta_r;   mul_b = pos_r[2]; end
      U_ZN:    begin mul_a = h_r;      mul_b = qsub(ta_r, tb_r); end
      default: begin mul_a = '0;       mul_b = '0; end
    endcase
  end

  lev_mul #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_go_r),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  // divisor |min| + max for the current axis
  always_comb begin
    case (axis_r)
      2'd0:    begin mn_sel = min_r[0]; mx_sel = max_r[0]; div_num = pos_r[0]; end
      2'd1:    begin mn_sel = min_r[1]; mx_sel = max_r[1]; div_num = pos_r[1]; end
      default: begin mn_sel = min_r[2]; mx_sel = max_r[2]; div_num = pos_r[2]; end
    endcase
    if (mn_sel[W-1]) span_abs = (mn_sel == WMIN) ? WMAX : -mn_sel;
    else             span_abs = mn_sel;
    span = qadd(span_abs, mx_sel);
  end

  lev_div #(
    .WORD_BITS (WORD_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (div_num),
    .den   (span),
    .done  (div_done),
    .quot  (div_q)
  );

  // step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      uop_r       <= U_HSIG;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      pos_r[0]    <= STARTX_64[W-1:0];
      pos_r[1]    <= '0;
      pos_r[2]    <= '0;
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= '0;
        max_r[i] <= MILLION;
      end
    end else begin
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            idx_r <= '0;
            uop_r <= U_HSIG;
            case (in_op)
              OP_STEP: begin
                len_r    <= LW'(1);
                burst_r  <= 1'b0;
                mul_go_r <= 1'b1;
                state_r  <= ST_MUL;
              end
              OP_BURST: begin
                len_r   <= len_clamp;
                burst_r <= 1'b1;
                if (len_clamp != '0) begin
                  mul_go_r <= 1'b1;
                  state_r  <= ST_MUL;
                end
              end
              OP_RESTART: begin
                pos_r[0] <= sx_r;
                pos_r[1] <= sy_r;
                pos_r[2] <= sz_r;
                cnt_r    <= '0;
                for (int i = 0; i < 3; i++) begin
                  min_r[i] <= '0;
                  max_r[i] <= MILLION;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            case (uop_r)
              U_HSIG:  ta_r     <= mul_res;
              U_XN:    np_r[0]  <= qadd(pos_r[0], mul_res);
              U_XRZ:   ta_r     <= mul_res;
              U_YN:    np_r[1]  <= qadd(pos_r[1], mul_res);
              U_XY:    ta_r     <= mul_res;
              U_BZ:    tb_r     <= mul_res;
              U_ZN:    np_r[2]  <= qadd(pos_r[2], mul_res);
              default: ;
            endcase
            if (uop_r == U_ZN) begin
              state_r <= ST_UPD;
            end else begin
              uop_r    <= uop_r + 1'b1;
              mul_go_r <= 1'b1;
            end
          end
        end
        ST_UPD: begin
          // commit position and widen the span
          for (int i = 0; i < 3; i++) begin
            pos_r[i] <= np_r[i];
            if (np_r[i] > max_r[i]) max_r[i] <= np_r[i];
            if (np_r[i] < min_r[i]) min_r[i] <= np_r[i];
          end
          axis_r   <= 2'd0;
          div_go_r <= 1'b1;
          state_r  <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            norm_r[axis_r] <= (span > 0) ? div_q : '0;
            if (axis_r == 2'd2) begin
              snum_r      <= cnt_r;
              warm_ok_r   <= cnt_r > CNT_W'(warm_r);
              bidx_r      <= BIDX_W'(idx_r);
              last_r      <= (idx_r + 1'b1) == len_r;
              out_valid_r <= 1'b1;
              state_r     <= ST_OUT;
            end else begin
              axis_r   <= axis_r + 1'b1;
              div_go_r <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (cnt_r != '1) cnt_r <= cnt_r + 1'b1;
            if (last_r) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r    <= idx_r + 1'b1;
              uop_r    <= U_HSIG;
              mul_go_r <= 1'b1;
              state_r  <= ST_MUL;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result beat
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, bidx_r, snum_r, norm_r[2], norm_r[1], norm_r[0]};
  assign out_tuser  = {burst_r, warm_ok_r};
  assign out_tlast  = last_r;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lorenz_euler_normalized. An in-bench fixed-point
// Lorenz integrator predicts every normalized result beat; the stream sides
// idle and stall at random while register settings are swept between phases.
// ----------------------------------------------------------------------------
module tb;
  import lev_pkg::*;

  localparam longint WMAX       = (longint'(1) <<< 47) - 1;
  localparam longint WMIN       = -WMAX - 1;
  localparam longint CYCLE_CAP  = 100000000;
  localparam int     DRAIN_WAIT = 3000;

  typedef struct {
    logic [31:0] nx, ny, nz, step_no;
    logic        warm, burst;
    logic [5:0]  idx;
    logic        last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  lorenz_euler_normalized dut (.*);

  always #5 clk = ~clk;

  // model copy of registers and state
  longint sigma_q, rho_q, beta_q, h_q, sx_q, sy_q, sz_q;
  int unsigned warm_q;
  longint pos[3], amin[3], amax[3];
  int unsigned step_cnt;

  beat_t expected_beats[$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 1'b0;  // no idling on either side while set

  function automatic longint sat48(logic signed [127:0] v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return longint'(v);
  endfunction

  function automatic longint qadd(longint a, longint b);
    return sat48(a + b);
  endfunction

  function automatic longint qsub(longint a, longint b);
    return sat48(a - b);
  endfunction

  // exact product, floor shift by the fraction width, saturate
  function automatic longint qmul(longint a, longint b);
    logic signed [127:0] p;
    p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    return sat48(p >>> LEV_FRAC_BITS);
  endfunction

  // c / d as Q2.30, truncated toward zero, saturated to 32 bits
  function automatic logic [31:0] qnorm(longint c, longint d);
    logic signed [127:0] num, q;
    num = $signed({{64{c[63]}}, c}) <<< NORM_FRAC;
    q = num / $signed({{64{d[63]}}, d});
    if (q > 128'sd2147483647) return 32'h7fffffff;
    if (q < -128'sd2147483648) return 32'h80000000;
    return q[31:0];
  endfunction

  function automatic longint sext48(logic [63:0] v);
    logic signed [47:0] t;
    t = v[47:0];
    return longint'(t);
  endfunction

  function automatic void restart_state();
    pos[0] = sx_q; pos[1] = sy_q; pos[2] = sz_q;
    for (int i = 0; i < 3; i++) begin
      amin[i] = 0;
      amax[i] = longint'(1000000) <<< LEV_FRAC_BITS;
    end
    step_cnt = 0;
  endfunction

  // one Euler step; returns the beat it produces
  function automatic beat_t advance_lorenz(bit burst, int idx, bit last);
    longint np[3];
    longint a, d;
    logic [31:0] nv[3];
    beat_t b;
    np[0] = qadd(pos[0], qmul(qmul(h_q, sigma_q), qsub(pos[1], pos[0])));
    np[1] = qadd(pos[1], qmul(h_q, qsub(qmul(pos[0], qsub(rho_q, pos[2])), pos[1])));
    np[2] = qadd(pos[2], qmul(h_q, qsub(qmul(pos[0], pos[1]), qmul(beta_q, pos[2]))));
    for (int i = 0; i < 3; i++) begin
      if (np[i] > amax[i]) amax[i] = np[i];
      if (np[i] < amin[i]) amin[i] = np[i];
      a = amin[i] < 0 ? (amin[i] == WMIN ? WMAX : -amin[i]) : amin[i];
      d = qadd(a, amax[i]);
      nv[i] = d > 0 ? qnorm(np[i], d) : 32'd0;
      pos[i] = np[i];
    end
    b.nx = nv[0]; b.ny = nv[1]; b.nz = nv[2];
    b.step_no = step_cnt;
    b.warm = step_cnt > warm_q;
    b.burst = burst;
    b.idx = idx[5:0];
    b.last = last;
    if (step_cnt != 32'hffffffff) step_cnt++;
    return b;
  endfunction

  function automatic void predict_item(logic [1:0] op, logic [6:0] len);
    int n;
    n = len > LEV_MAX_BURST ? LEV_MAX_BURST : len;
    case (op)
      OP_STEP:    expected_beats.push_back(advance_lorenz(1'b0, 0, 1'b1));
      OP_BURST:   for (int k = 0; k < n; k++)
                    expected_beats.push_back(advance_lorenz(1'b1, k, k + 1 == n));
      OP_RESTART: restart_state();
      default: ;
    endcase
  endfunction

  function automatic int idle_gap(int long_max);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, long_max);
  endfunction

  // result side stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= idle_gap(4) == 0 ? 1'b1 : ($urandom_range(0, 9) == 0);
  end

  // result checker
  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, actual data=%h user=%b last=%b",
                 $realtime, out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        e = expected_beats.pop_front();
        if (out_tdata[31:0] !== e.nx || out_tdata[63:32] !== e.ny ||
            out_tdata[95:64] !== e.nz || out_tdata[127:96] !== e.step_no ||
            out_tdata[133:128] !== e.idx || out_tdata[135:134] !== 2'b00 ||
            out_tuser[0] !== e.warm || out_tuser[1] !== e.burst ||
            out_tlast !== e.last) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h n=%0d idx=%0d warm=%b burst=%b last=%b",
                   $realtime, e.nx, e.ny, e.nz, e.step_no, e.idx, e.warm, e.burst, e.last);
          $display("%0t:          actual   x=%h y=%h z=%h n=%0d idx=%0d warm=%b burst=%b last=%b",
                   $realtime, out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
                   out_tdata[127:96], out_tdata[133:128], out_tuser[0], out_tuser[1],
                   out_tlast);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // send one command beat; valid stays high when no gap follows
  task automatic send_item(logic [1:0] op, logic [6:0] len);
    int gap;
    in_tdata <= {7'd0, len, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_item(op, len);
    gap = idle_gap(60);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (in_tvalid) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // register write: setup then access phase; block is idle here
  task automatic write_reg(logic [REG_W-1:0] idx, logic [63:0] val);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'(idx) << 3;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_SIGMA:  sigma_q = sext48(val);
      REG_RHO:    rho_q = sext48(val);
      REG_BETA:   beta_q = sext48(val);
      REG_STEP:   h_q = sext48(val);
      REG_STARTX: sx_q = sext48(val);
      REG_STARTY: sy_q = sext48(val);
      REG_STARTZ: sz_q = sext48(val);
      REG_WARMUP: warm_q = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand_coef(longint nominal);
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = WMAX;
      1: v = WMIN;
      2: v = {$urandom(), $urandom()};
      default: v = nominal + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    endcase
    return v;
  endfunction

  task automatic write_defaults();
    write_reg(REG_SIGMA, longint'(10) <<< 24);
    write_reg(REG_RHO, longint'(28) <<< 24);
    write_reg(REG_BETA, 64'd44739243);
    write_reg(REG_STEP, 64'd167772);
    write_reg(REG_STARTX, 64'd1677722);
    write_reg(REG_STARTY, 64'd0);
    write_reg(REG_STARTZ, 64'd0);
  endtask

  // reset defaults: steps, bursts of every size class, restart, unused code
  task automatic test_defaults();
    quiet = 1'b1;
    send_item(OP_STEP, 7'd0);
    send_item(OP_STEP, 7'h7f);
    send_item(OP_BURST, 7'd1);
    send_item(OP_BURST, 7'd0);
    send_item(OP_BURST, 7'd64);
    quiet = 1'b0;
    send_item(2'd3, 7'd5);
    send_item(OP_STEP, 7'd0);
    send_item(OP_BURST, 7'd127);
    send_item(OP_RESTART, 7'd9);
    send_item(OP_BURST, 7'd3);
    drain();
  endtask

  // warm-up flag around small thresholds and at the largest one
  task automatic test_warmup();
    write_reg(REG_WARMUP, 64'd0);
    send_item(OP_RESTART, 7'd0);
    send_item(OP_BURST, 7'd4);
    drain();
    write_reg(REG_WARMUP, 64'hffff_ffff_0000_0003);
    send_item(OP_RESTART, 7'd0);
    send_item(OP_BURST, 7'd6);
    send_item(OP_STEP, 7'd0);
    drain();
    write_reg(REG_WARMUP, 64'd65535);
    send_item(OP_BURST, 7'd2);
    drain();
  endtask

  // saturating corners of every signed register
  task automatic test_extremes();
    write_reg(REG_SIGMA, WMAX);
    write_reg(REG_RHO, WMIN);
    write_reg(REG_BETA, WMAX);
    write_reg(REG_STEP, WMAX);
    write_reg(REG_STARTX, WMIN);
    write_reg(REG_STARTY, WMAX);
    write_reg(REG_STARTZ, 64'hffff_0000_0000_0000);
    send_item(OP_RESTART, 7'd0);
    send_item(OP_BURST, 7'd5);
    drain();
    write_reg(REG_SIGMA, WMIN);
    write_reg(REG_RHO, WMAX);
    write_reg(REG_STEP, WMIN);
    write_reg(REG_STARTX, WMAX);
    write_reg(REG_STARTY, WMIN);
    write_reg(REG_STARTZ, WMAX);
    send_item(OP_RESTART, 7'd0);
    send_item(OP_STEP, 7'd0);
    send_item(OP_BURST, 7'd3);
    drain();
    write_defaults();
  endtask

  // random command mix across several register settings
  task automatic test_random(int items);
    int r;
    logic [6:0] len;
    for (int i = 0; i < items; i++) begin
      if (i % 75 == 74) begin
        drain();
        if ($urandom_range(0, 2) == 0) write_defaults();
        else begin
          write_reg(REG_SIGMA, rand_coef(longint'(10) <<< 24));
          write_reg(REG_RHO, rand_coef(longint'(28) <<< 24));
          write_reg(REG_BETA, rand_coef(44739243));
          write_reg(REG_STEP, rand_coef(167772));
          write_reg(REG_STARTX, rand_coef(1677722));
          write_reg(REG_STARTY, rand_coef(0));
          write_reg(REG_STARTZ, rand_coef(0));
        end
        write_reg(REG_WARMUP, $urandom_range(0, 40));
        quiet = $urandom_range(0, 3) == 0;
      end
      // one hold-off until the block has nothing left to report
      if (i == items / 2) drain();
      r = $urandom_range(0, 99);
      len = $urandom_range(0, 4);
      if (r < 2) len = $urandom_range(65, 127);
      else if (r < 10) len = $urandom_range(5, 20);
      if (r < 40) send_item(OP_STEP, $urandom_range(0, 127));
      else if (r < 85) send_item(OP_BURST, len);
      else if (r < 95) send_item(OP_RESTART, $urandom_range(0, 127));
      else send_item(2'd3, $urandom_range(0, 127));
    end
    drain();
  endtask

  initial begin
    sigma_q = longint'(10) <<< 24;
    rho_q = longint'(28) <<< 24;
    beta_q = 44739243;
    h_q = 167772;
    sx_q = 1677722;
    sy_q = 0;
    sz_q = 0;
    warm_q = 1000;
    restart_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_warmup();
    test_extremes();
    test_random(350);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
